// File: rtl/core/lisp_lex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lisp lexer package
// Token and error codes, character constants and byte classifiers shared
// by the lexer RTL.
// ----------------------------------------------------------------------------
package lisp_lex_pkg;

   // Default counter widths
   localparam int LINE_BITS_DEF   = 20;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int OFFSET_BITS_DEF = 24;

   // Result queue depth (room for two words per step plus slack)
   localparam int RSP_DEPTH = 4;

   // Input command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   typedef enum logic [3:0] {
      TK_LPAREN   = 4'd0,
      TK_RPAREN   = 4'd1,
      TK_LBRACKET = 4'd2,
      TK_RBRACKET = 4'd3,
      TK_NUMBER   = 4'd4,
      TK_SYMBOL   = 4'd5,
      TK_STRING   = 4'd6,
      TK_EOF      = 4'd7,
      TK_ERROR    = 4'd8
   } tok_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_UNEXPECTED   = 2'd1,
      ERR_UNTERMINATED = 2'd2
   } err_kind_type;

   // Lexer modes, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_NUMBER = 5'b00010,
      MODE_SYMBOL = 5'b00100,
      MODE_STRING = 5'b01000,
      MODE_ESCAPE = 5'b10000
   } lex_mode_type;

   // Characters
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_SPACE    = 8'h20;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      logic alnum;
      alnum = is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
              ((c >= 8'h41) && (c <= 8'h5A));
      return alnum || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) ||
             (c == 8'h2F) || (c == 8'h3D) || (c == 8'h21) || (c == 8'h3C) ||
             (c == 8'h3E) || (c == 8'h3F) || (c == 8'h5F) || (c == CH_DOT);
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
             (c == CH_CR) || (c == CH_COMMA);
   endfunction

   function automatic logic is_bracket(input logic [7:0] c);
      return (c == CH_LPAREN) || (c == CH_RPAREN) ||
             (c == CH_LBRACKET) || (c == CH_RBRACKET);
   endfunction

endpackage

// File: rtl/core/lisp_token_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lisp token lexer
// Streams source bytes, tracks line/column/offset and emits token words.
// Output: a token word enters the result queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while req_ready is high; a step can yield two
//   words into the 4-entry result queue, so req_ready drops while < 2 free.
// Reset: synchronous, active high; mode idle, line/column 1, offset 0,
//   result queue empty.
// ----------------------------------------------------------------------------
module lisp_token_lexer_top #(
   parameter int LINE_BITS   = lisp_lex_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = lisp_lex_pkg::COLUMN_BITS_DEF,
   parameter int OFFSET_BITS = lisp_lex_pkg::OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input words
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [7:0]             req_byte_value,
   // Result words
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_token_kind,
   output logic [1:0]             rsp_error_kind,
   output logic [LINE_BITS-1:0]   rsp_token_line,
   output logic [COLUMN_BITS-1:0] rsp_start_column,
   output logic [OFFSET_BITS-1:0] rsp_value_offset,
   output logic [OFFSET_BITS-1:0] rsp_value_length,
   output logic [7:0]             rsp_bad_char,
   output logic                   rsp_last
);

   localparam int DEPTH    = lisp_lex_pkg::RSP_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   typedef struct packed {
      lisp_lex_pkg::tok_kind_type kind;
      lisp_lex_pkg::err_kind_type err;
      logic [LINE_BITS-1:0]       line;
      logic [COLUMN_BITS-1:0]     col;
      logic [OFFSET_BITS-1:0]     off;
      logic [OFFSET_BITS-1:0]     len;
      logic [7:0]                 bad;
      logic                       last;
   } rec_type;

   // Lexer state
   lisp_lex_pkg::lex_mode_type mode_ff, mode_in;
   logic [LINE_BITS-1:0]       line_ff, line_in, tok_line_ff, tok_line_in;
   logic [COLUMN_BITS-1:0]     col_ff, col_in, tok_col_ff, tok_col_in;
   logic [OFFSET_BITS-1:0]     off_ff, off_in, tok_off_ff, tok_off_in;

   // Result queue
   rec_type                    q_mem [DEPTH];
   logic [PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;

   logic                       req_acc, rsp_acc;
   logic [7:0]                 c;
   logic [LINE_BITS-1:0]       take_line;
   logic [COLUMN_BITS-1:0]     take_col;
   logic [OFFSET_BITS-1:0]     take_off;
   rec_type                    pend_rec, cur_rec, eof_rec, rec_a, rec_b, rec0, rec1;
   logic                       has_a, has_b;
   logic [1:0]                 n_rec;
   rec_type                    head;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign c       = req_byte_value;

   // Counters after taking the current byte, saturating
   assign take_line = (c == lisp_lex_pkg::CH_NL && line_ff != '1) ?
                      line_ff + 1'b1 : line_ff;
   assign take_col  = (c == lisp_lex_pkg::CH_NL) ? COLUMN_BITS'(1) :
                      ((col_ff != '1) ? col_ff + 1'b1 : col_ff);
   assign take_off  = (off_ff != '1) ? off_ff + 1'b1 : off_ff;

   // Candidate words
   always_comb begin
      pend_rec      = '0;
      pend_rec.kind = lisp_lex_pkg::TK_NUMBER;
      pend_rec.err  = lisp_lex_pkg::ERR_NONE;
      pend_rec.line = tok_line_ff;
      pend_rec.col  = tok_col_ff;
      pend_rec.off  = tok_off_ff;
      pend_rec.len  = off_ff - tok_off_ff;
      unique case (1'b1)
         mode_ff[2]: pend_rec.kind = lisp_lex_pkg::TK_SYMBOL;
         mode_ff[3], mode_ff[4]: begin
            pend_rec.kind = lisp_lex_pkg::TK_ERROR;
            pend_rec.err  = lisp_lex_pkg::ERR_UNTERMINATED;
         end
         default: pend_rec.kind = lisp_lex_pkg::TK_NUMBER;
      endcase

      eof_rec      = '0;
      eof_rec.kind = lisp_lex_pkg::TK_EOF;
      eof_rec.err  = lisp_lex_pkg::ERR_NONE;
      eof_rec.line = line_ff;
      eof_rec.col  = col_ff;
      eof_rec.off  = off_ff;

      cur_rec      = '0;
      cur_rec.err  = lisp_lex_pkg::ERR_NONE;
      cur_rec.line = line_ff;
      cur_rec.col  = col_ff;
      cur_rec.off  = off_ff;
      cur_rec.len  = OFFSET_BITS'(1);
      priority if (c == lisp_lex_pkg::CH_LPAREN) begin
         cur_rec.kind = lisp_lex_pkg::TK_LPAREN;
      end else if (c == lisp_lex_pkg::CH_RPAREN) begin
         cur_rec.kind = lisp_lex_pkg::TK_RPAREN;
      end else if (c == lisp_lex_pkg::CH_LBRACKET) begin
         cur_rec.kind = lisp_lex_pkg::TK_LBRACKET;
      end else if (c == lisp_lex_pkg::CH_RBRACKET) begin
         cur_rec.kind = lisp_lex_pkg::TK_RBRACKET;
      end else begin
         cur_rec.kind = lisp_lex_pkg::TK_ERROR;
         cur_rec.err  = lisp_lex_pkg::ERR_UNEXPECTED;
         cur_rec.bad  = c;
      end
   end

   // Next lexer state and the words this step yields
   always_comb begin
      mode_in     = mode_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      off_in      = off_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      tok_off_in  = tok_off_ff;
      has_a       = 1'b0;
      has_b       = 1'b0;
      rec_a       = pend_rec;
      rec_b       = cur_rec;

      if (req_cmd == lisp_lex_pkg::CMD_EOF) begin
         // Flush any open token, then EOF, then back to reset values
         has_a       = (mode_ff != lisp_lex_pkg::MODE_IDLE);
         has_b       = 1'b1;
         rec_b       = eof_rec;
         mode_in     = lisp_lex_pkg::MODE_IDLE;
         line_in     = LINE_BITS'(1);
         col_in      = COLUMN_BITS'(1);
         off_in      = '0;
         tok_line_in = LINE_BITS'(1);
         tok_col_in  = COLUMN_BITS'(1);
         tok_off_in  = '0;
      end else begin
         line_in = take_line;
         col_in  = take_col;
         off_in  = take_off;
         unique case (mode_ff)
            lisp_lex_pkg::MODE_STRING: begin
               if (c == lisp_lex_pkg::CH_QUOTE) begin
                  has_a         = 1'b1;
                  rec_a.kind    = lisp_lex_pkg::TK_STRING;
                  rec_a.err     = lisp_lex_pkg::ERR_NONE;
                  mode_in       = lisp_lex_pkg::MODE_IDLE;
               end else if (c == lisp_lex_pkg::CH_BSLASH) begin
                  mode_in = lisp_lex_pkg::MODE_ESCAPE;
               end
            end
            lisp_lex_pkg::MODE_ESCAPE: mode_in = lisp_lex_pkg::MODE_STRING;
            default: begin
               // Number or symbol continues on its own characters
               if ((mode_ff == lisp_lex_pkg::MODE_NUMBER &&
                    (lisp_lex_pkg::is_digit(c) || c == lisp_lex_pkg::CH_DOT)) ||
                   (mode_ff == lisp_lex_pkg::MODE_SYMBOL &&
                    lisp_lex_pkg::is_name_char(c))) begin
                  mode_in = mode_ff;
               end else begin
                  has_a   = (mode_ff != lisp_lex_pkg::MODE_IDLE);
                  mode_in = lisp_lex_pkg::MODE_IDLE;
                  // Lex the byte from idle
                  priority if (lisp_lex_pkg::is_separator(c)) begin
                     has_b = 1'b0;
                  end else if (lisp_lex_pkg::is_bracket(c)) begin
                     has_b = 1'b1;
                  end else if (c == lisp_lex_pkg::CH_QUOTE) begin
                     tok_line_in = line_ff;
                     tok_col_in  = col_ff;
                     tok_off_in  = take_off;
                     mode_in     = lisp_lex_pkg::MODE_STRING;
                  end else if (lisp_lex_pkg::is_name_char(c)) begin
                     tok_line_in = line_ff;
                     tok_col_in  = col_ff;
                     tok_off_in  = off_ff;
                     mode_in     = lisp_lex_pkg::is_digit(c) ?
                                   lisp_lex_pkg::MODE_NUMBER :
                                   lisp_lex_pkg::MODE_SYMBOL;
                  end else begin
                     has_b = 1'b1;
                  end
               end
            end
         endcase
      end

      // Pack the words; last marks the final one
      rec_a.last = !has_b;
      rec_b.last = 1'b1;
      rec0       = has_a ? rec_a : rec_b;
      rec1       = rec_b;
      n_rec      = {1'b0, has_a} + {1'b0, has_b};
   end

   // Queue pointers and count
   assign req_ready = (cnt_ff <= CNT_BITS'(DEPTH - 2));
   assign rsp_valid = (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (req_acc) begin
         wr_ptr_in = wr_ptr_ff + PTR_BITS'(n_rec);
         cnt_in    = cnt_ff + CNT_BITS'(n_rec);
      end
      if (rsp_acc) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         cnt_in    = cnt_in - 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= lisp_lex_pkg::MODE_IDLE;
         line_ff     <= LINE_BITS'(1);
         col_ff      <= COLUMN_BITS'(1);
         off_ff      <= '0;
         tok_line_ff <= LINE_BITS'(1);
         tok_col_ff  <= COLUMN_BITS'(1);
         tok_off_ff  <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         if (req_acc) begin
            mode_ff     <= mode_in;
            line_ff     <= line_in;
            col_ff      <= col_in;
            off_ff      <= off_in;
            tok_line_ff <= tok_line_in;
            tok_col_ff  <= tok_col_in;
            tok_off_ff  <= tok_off_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (req_acc && n_rec != 2'd0) begin
         q_mem[wr_ptr_ff] <= rec0;
         if (n_rec == 2'd2) begin
            q_mem[wr_ptr_ff + 1'b1] <= rec1;
         end
      end
   end

   // Result word at the head
   assign head             = q_mem[rd_ptr_ff];
   assign rsp_token_kind   = head.kind;
   assign rsp_error_kind   = head.err;
   assign rsp_token_line   = head.line;
   assign rsp_start_column = head.col;
   assign rsp_value_offset = head.off;
   assign rsp_value_length = head.len;
   assign rsp_bad_char     = head.bad;
   assign rsp_last         = head.last;

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(DEPTH))
      else $error("result queue count exceeds depth");

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_cmd == lisp_lex_pkg::CMD_EOF) |=>
      (mode_ff == lisp_lex_pkg::MODE_IDLE && off_ff == '0))
      else $error("state not cleared after end of input");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0 && col_ff != '0)
      else $error("line or column counter reached zero");

   a_tok_before_off: assert property (@(posedge clock) disable iff (reset)
      tok_off_ff <= off_ff)
      else $error("token start offset ahead of byte offset");

endmodule
